### hdl/tmn_pkg.sv
`default_nettype none
package tmn_pkg;
   localparam int CMD_W   = 16;
   localparam int SUM_W   = 18;
   localparam int MAG_W   = 17;
   localparam int OUT_W   = 16;
   localparam int QUO_W   = 15;
   localparam int NUM_W   = MAG_W + 14;
   localparam int STEPS   = QUO_W;
   localparam logic [MAG_W-1:0] FULL_SCALE = MAG_W'(16384);

   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic [MAG_W-1:0]        mag_type;

   // one drive on its way through the divider row
   typedef struct packed {
      logic                neg;
      logic [NUM_W-1:0]    num;   // remaining dividend bits, shifted up
      logic [MAG_W:0]      rem;
      logic [QUO_W-1:0]    quo;
   } lane_type;

   typedef struct packed {
      logic                sat;
      mag_type             peak;
      lane_type [3:0]      lane;
   } grp_type;

   typedef struct packed {
      logic    valid;
      grp_type h;
      grp_type v;
   } slot_type;
endpackage
`default_nettype wire

### hdl/thruster_mixer_normalizer.sv
`default_nettype none
// Thruster mixer: six Q3.12 axis commands in, eight Q1.14 drives out, one word per
// cycle when both sides flow. Pipeline: one mix stage, one peak stage, 15
// restoring-division cells (one quotient bit each) and one output stage. Stalls on
// rsp_tready freeze the whole row.
module thruster_mixer_normalizer (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // surge[15:0] sway[31:16] heave[47:32] roll[63:48] pitch[79:64] yaw[95:80]
   input  wire  [95:0]  req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // h0 h1 h2 h3 v0 v1 v2 v3, 16 bits each from bit 0 up
   output logic [127:0] rsp_tdata
);
   import tmn_pkg::*;

   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // mix stage
   logic    mix_vld_ff;
   sum_type mix_ff [8];
   sum_type mix_in [8];
   sum_type ax [6];

   always_comb begin
      for (int j = 0; j < 6; j++)
         ax[j] = SUM_W'($signed(req_tdata[16*j +: 16]));
      mix_in[0] =  ax[0] - ax[1] + ax[5];
      mix_in[1] =  ax[0] + ax[1] - ax[5];
      mix_in[2] = -ax[0] + ax[1] + ax[5];
      mix_in[3] = -ax[0] - ax[1] - ax[5];
      mix_in[4] =  ax[2] - ax[3] + ax[4];
      mix_in[5] =  ax[2] + ax[3] + ax[4];
      mix_in[6] =  ax[2] - ax[3] - ax[4];
      mix_in[7] =  ax[2] + ax[3] - ax[4];
   end

   always_ff @(posedge clock) begin
      if (reset) mix_vld_ff <= 1'b0;
      else if (advance) mix_vld_ff <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (advance) for (int i = 0; i < 8; i++) mix_ff[i] <= mix_in[i];
   end

   // peak stage: magnitudes, group maximum, divider setup
   function automatic grp_type setup(sum_type d0, sum_type d1, sum_type d2, sum_type d3);
      grp_type g;
      mag_type m [4];
      sum_type d [4];
      d[0] = d0; d[1] = d1; d[2] = d2; d[3] = d3;
      g.peak = '0;
      for (int k = 0; k < 4; k++) begin
         m[k] = d[k][SUM_W-1] ? MAG_W'(-d[k]) : MAG_W'(d[k]);
         if (m[k] > g.peak) g.peak = m[k];
      end
      g.sat = g.peak > FULL_SCALE;
      for (int k = 0; k < 4; k++) begin
         g.lane[k].neg = d[k][SUM_W-1];
         g.lane[k].num = {m[k], 14'd0};
         g.lane[k].rem = '0;
         g.lane[k].quo = QUO_W'(m[k]);  // passes through when unsaturated
      end
      // quotient < 2^15, so the top 16 dividend bits are already below peak
      for (int k = 0; k < 4; k++)
         if (g.sat) begin
            g.lane[k].rem = {2'b00, m[k][MAG_W-1:1]};
            g.lane[k].num = {m[k], 14'd0} << (NUM_W - QUO_W);
            g.lane[k].quo = '0;
         end
      return g;
   endfunction

   slot_type row0_ff;
   slot_type row [STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) row0_ff.valid <= 1'b0;
      else if (advance) begin
         row0_ff.valid <= mix_vld_ff;
         row0_ff.h <= setup(mix_ff[0], mix_ff[1], mix_ff[2], mix_ff[3]);
         row0_ff.v <= setup(mix_ff[4], mix_ff[5], mix_ff[6], mix_ff[7]);
      end
   end

   assign row[0] = row0_ff;

   for (genvar c = 0; c < STEPS; c++) begin : g_cell
      tmn_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .slot_i  (row[c]),
         .slot_o  (row[c+1])
      );
   end

   // output stage: pick divided or raw magnitude, restore sign
   slot_type last;
   logic [QUO_W-1:0] qv [8];
   logic [127:0] data_in;
   assign last = row[STEPS];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         qv[k]   = last.h.sat ? last.h.lane[k].quo
                              : QUO_W'(last.h.lane[k].num[NUM_W-1 -: MAG_W]);
         qv[k+4] = last.v.sat ? last.v.lane[k].quo
                              : QUO_W'(last.v.lane[k].num[NUM_W-1 -: MAG_W]);
         data_in[16*k +: 16]     = last.h.lane[k].neg ? -{1'b0, qv[k]} : {1'b0, qv[k]};
         data_in[16*(k+4) +: 16] = last.v.lane[k].neg ? -{1'b0, qv[k+4]} : {1'b0, qv[k+4]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid <= 1'b0;
      else if (advance) rsp_tvalid <= last.valid;
   end
   always_ff @(posedge clock) begin
      if (advance) rsp_tdata <= data_in;
   end

`ifndef SYNTHESIS
   function automatic logic drives_in_range(logic [127:0] w);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < 8; i++)
         if ($signed(w[16*i +: 16]) > 16'sd16384 || $signed(w[16*i +: 16]) < -16'sd16384)
            ok = 1'b0;
      return ok;
   endfunction

   a_reset_clears_valid: assert property (@(posedge clock) reset |=> !rsp_tvalid);
   a_hold_while_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata));
   a_ready_follows_output: assert property (@(posedge clock)
      req_tready == (!rsp_tvalid || rsp_tready));
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> drives_in_range(rsp_tdata));
`endif
endmodule
`default_nettype wire

### hdl/tmn_cell.sv
`default_nettype none
// One restoring-division step for saturated groups; one bit of quotient per cell.
module tmn_cell (
   input  wire                clock,
   input  wire                reset,
   input  wire                advance,
   input  tmn_pkg::slot_type  slot_i,
   output tmn_pkg::slot_type  slot_o
);
   import tmn_pkg::*;

   slot_type slot_ff, slot_in;

   // an unsaturated group carries its raw magnitudes through untouched
   function automatic grp_type step(grp_type g);
      grp_type r;
      logic [MAG_W:0] t;
      r = g;
      if (g.sat) begin
         for (int k = 0; k < 4; k++) begin
            t = {g.lane[k].rem[MAG_W-1:0], g.lane[k].num[NUM_W-1]};
            r.lane[k].num = {g.lane[k].num[NUM_W-2:0], 1'b0};
            if (t >= {1'b0, g.peak}) begin
               r.lane[k].rem = t - {1'b0, g.peak};
               r.lane[k].quo = {g.lane[k].quo[QUO_W-2:0], 1'b1};
            end else begin
               r.lane[k].rem = t;
               r.lane[k].quo = {g.lane[k].quo[QUO_W-2:0], 1'b0};
            end
         end
      end
      return r;
   endfunction

   always_comb begin
      slot_in       = slot_i;
      slot_in.h     = step(slot_i.h);
      slot_in.v     = step(slot_i.v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else if (advance) begin
         slot_ff <= slot_in;
      end
   end

   assign slot_o = slot_ff;
endmodule
`default_nettype wire
